// ----- design/sbp_pkg.sv -----
// Shared types and constants for the scanline block pixelation core.
`timescale 1ns / 1ps
`default_nettype none

package sbp_pkg;

  localparam int unsigned PIX_W  = 16;
  localparam int unsigned CNT_W  = 5;   // holds a block length of 1..16
  localparam int unsigned RSUM_W = 9;
  localparam int unsigned GSUM_W = 10;
  localparam int unsigned BSUM_W = 9;
  localparam int unsigned DVD_W  = 10;  // common dividend width of the three dividers
  localparam int unsigned STEP_W = 4;
  localparam int unsigned WGT_W  = 9;
  localparam int unsigned BSZ_W  = 5;
  localparam int unsigned CFG_AW = 2;
  localparam int unsigned CFG_DW = 9;
  localparam int unsigned MAX_SIZE = 16;

  localparam logic [STEP_W-1:0] DIV_LAST_STEP = STEP_W'(DVD_W - 1);
  localparam logic [WGT_W-1:0]  WGT_FULL      = 9'd256;

  localparam logic [CFG_AW-1:0] CFG_ENABLE = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_BSIZE  = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_WEIGHT = 2'd2;

  // One closed block handed from the front to the back.
  typedef struct packed {
    logic              bank;
    logic [CNT_W-1:0]  cnt;
    logic [RSUM_W-1:0] red_sum;
    logic [GSUM_W-1:0] grn_sum;
    logic [BSUM_W-1:0] blu_sum;
    logic              line_end;
  } desc_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_EMIT = 3'b100
  } back_state_e;

endpackage

`default_nettype wire

// ----- design/sbp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module sbp_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 32
) (
  input  wire                      clk_i,
  input  wire                      we_i,
  input  wire  [$clog2(DEPTH)-1:0] waddr_i,
  input  wire  [WIDTH-1:0]         wdata_i,
  input  wire                      re_i,
  input  wire  [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- design/sbp_fifo.sv -----
// Small FIFO that carries closed-block descriptors from front to back.
`timescale 1ns / 1ps
`default_nettype none

module sbp_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              push_i,
  input  wire  [WIDTH-1:0] wdata_i,
  input  wire              pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o,
  output logic             full_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] buf_q [DEPTH];
  logic [PW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CW'(DEPTH));
  assign rdata_o = buf_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wptr_q] <= wdata_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i))
    else $error("descriptor FIFO overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("descriptor FIFO underflow");

endmodule

`default_nettype wire

// ----- design/sbp_front.sv -----
// Front end: takes pixels, stores them per block, sums channels, closes blocks.
`timescale 1ns / 1ps
`default_nettype none

module sbp_front
  import sbp_pkg::*;
#(
  parameter int unsigned BLK = 16,
  parameter int unsigned IW  = 4
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_ready_o,
  input  wire  [PIX_W-1:0]  pixel_i,
  input  wire               line_end_i,
  input  wire               bank_free_i,
  input  wire               enable_i,
  input  wire  [BSZ_W-1:0]  block_size_i,
  output logic              wr_en_o,
  output logic [IW:0]       wr_addr_o,
  output logic [PIX_W-1:0]  wr_data_o,
  output logic              push_o,
  output desc_t             desc_o
);

  logic [CNT_W-1:0]  fill_q, fill_d;
  logic [RSUM_W-1:0] rsum_q, rsum_d;
  logic [GSUM_W-1:0] gsum_q, gsum_d;
  logic [BSUM_W-1:0] bsum_q, bsum_d;
  logic              bank_q, bank_d;

  logic              accept;
  logic              close;
  logic [CNT_W-1:0]  cnt_inc;
  logic [CNT_W-1:0]  eff;
  logic [RSUM_W-1:0] rtot;
  logic [GSUM_W-1:0] gtot;
  logic [BSUM_W-1:0] btot;

  assign in_ready_o = bank_free_i;
  assign accept     = in_valid_i && bank_free_i;

  assign wr_en_o   = accept;
  assign wr_addr_o = {bank_q, fill_q[IW-1:0]};
  assign wr_data_o = pixel_i;

  always_comb begin
    if (block_size_i < BSZ_W'(2)) begin
      eff = CNT_W'(2);
    end else if (block_size_i > BSZ_W'(BLK)) begin
      eff = CNT_W'(BLK);
    end else begin
      eff = block_size_i;
    end

    cnt_inc = fill_q + 1'b1;
    rtot    = rsum_q + RSUM_W'(pixel_i[15:11]);
    gtot    = gsum_q + GSUM_W'(pixel_i[10:5]);
    btot    = bsum_q + BSUM_W'(pixel_i[4:0]);
    close   = !enable_i || line_end_i || (cnt_inc >= eff);

    desc_o.bank     = bank_q;
    desc_o.cnt      = cnt_inc;
    desc_o.red_sum  = rtot;
    desc_o.grn_sum  = gtot;
    desc_o.blu_sum  = btot;
    desc_o.line_end = line_end_i;
    push_o          = accept && close;

    fill_d = fill_q;
    rsum_d = rsum_q;
    gsum_d = gsum_q;
    bsum_d = bsum_q;
    bank_d = bank_q;
    if (accept) begin
      if (close) begin
        fill_d = '0;
        rsum_d = '0;
        gsum_d = '0;
        bsum_d = '0;
        bank_d = !bank_q;
      end else begin
        fill_d = cnt_inc;
        rsum_d = rtot;
        gsum_d = gtot;
        bsum_d = btot;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      rsum_q <= '0;
      gsum_q <= '0;
      bsum_q <= '0;
      bank_q <= 1'b0;
    end else begin
      fill_q <= fill_d;
      rsum_q <= rsum_d;
      gsum_q <= gsum_d;
      bsum_q <= bsum_d;
      bank_q <= bank_d;
    end
  end

  a_fill_in_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q < CNT_W'(BLK))
    else $error("open block holds a full block without closing");

endmodule

`default_nettype wire

// ----- design/sbp_back.sv -----
// Back end: divides block sums into means, then reads out and blends each pixel.
`timescale 1ns / 1ps
`default_nettype none

module sbp_back
  import sbp_pkg::*;
#(
  parameter int unsigned IW = 4
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               desc_valid_i,
  input  desc_t             desc_i,
  output logic              pop_o,
  input  wire               enable_i,
  input  wire  [WGT_W-1:0]  weight_i,
  output logic              rd_en_o,
  output logic [IW:0]       rd_addr_o,
  input  wire  [PIX_W-1:0]  rd_data_i,
  output logic              out_valid_o,
  input  wire               out_ready_i,
  output logic [PIX_W-1:0]  out_pixel_o,
  output logic              out_run_last_o,
  output logic              out_line_last_o,
  output logic              done_o
);

  back_state_e       state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              bank_q, bank_d;
  logic              lend_q, lend_d;
  logic [DVD_W-1:0]  dr_q, dr_d, dg_q, dg_d, db_q, db_d;
  logic [CNT_W-1:0]  rr_q, rr_d, rg_q, rg_d, rb_q, rb_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [CNT_W-1:0]  rd_idx_q, rd_idx_d;
  logic [CNT_W-1:0]  ld_idx_q, ld_idx_d;
  logic              rd_vld_q, rd_vld_d;
  logic              ov_q, ov_d;
  logic [PIX_W-1:0]  opix_q, opix_d;
  logic              orun_q, orun_d;
  logic              oline_q, oline_d;

  logic              ld_last;
  logic [WGT_W-1:0]  wgt;
  logic [PIX_W-1:0]  blended;

  // One restoring-division step: shift in the next dividend bit, subtract if it fits.
  function automatic logic [CNT_W+DVD_W-1:0] div_step(
    input logic [CNT_W-1:0] rem,
    input logic [DVD_W-1:0] dvd,
    input logic [CNT_W-1:0] den
  );
    logic [CNT_W:0] sh;
    logic           ge;
    logic [CNT_W:0] nr;
    sh = {rem, dvd[DVD_W-1]};
    ge = (sh >= {1'b0, den});
    nr = ge ? (sh - {1'b0, den}) : sh;
    return {nr[CNT_W-1:0], dvd[DVD_W-2:0], ge};
  endfunction

  // (orig*(256-w) + avg*w) >> 8 on one channel of up to 6 bits.
  function automatic logic [5:0] mix(
    input logic [5:0]       orig,
    input logic [5:0]       avg,
    input logic [WGT_W-1:0] w
  );
    logic [WGT_W-1:0] winv;
    logic [15:0]      acc;
    winv = WGT_FULL - w;
    acc  = 16'(orig) * 16'(winv) + 16'(avg) * 16'(w);
    return acc[13:8];
  endfunction

  assign wgt = (weight_i > WGT_FULL) ? WGT_FULL : weight_i;

  always_comb begin
    logic [5:0] mr, mg, mb;
    mr = mix({1'b0, rd_data_i[15:11]}, {1'b0, dr_q[4:0]}, wgt);
    mg = mix(rd_data_i[10:5], dg_q[5:0], wgt);
    mb = mix({1'b0, rd_data_i[4:0]}, {1'b0, db_q[4:0]}, wgt);
    if (enable_i) begin
      blended = {mr[4:0], mg, mb[4:0]};
    end else begin
      blended = rd_data_i;
    end
  end

  assign ld_last = rd_vld_q && (ld_idx_q == cnt_q - 1'b1);

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    bank_d   = bank_q;
    lend_d   = lend_q;
    dr_d     = dr_q;
    dg_d     = dg_q;
    db_d     = db_q;
    rr_d     = rr_q;
    rg_d     = rg_q;
    rb_d     = rb_q;
    step_d   = step_q;
    rd_idx_d = rd_idx_q;
    ld_idx_d = ld_idx_q;
    rd_vld_d = 1'b0;
    ov_d     = ov_q && !out_ready_i;
    opix_d   = opix_q;
    orun_d   = orun_q;
    oline_d  = oline_q;
    pop_o    = 1'b0;
    rd_en_o  = 1'b0;
    done_o   = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (desc_valid_i) begin
          pop_o   = 1'b1;
          cnt_d   = desc_i.cnt;
          bank_d  = desc_i.bank;
          lend_d  = desc_i.line_end;
          dr_d    = DVD_W'(desc_i.red_sum);
          dg_d    = desc_i.grn_sum;
          db_d    = DVD_W'(desc_i.blu_sum);
          rr_d    = '0;
          rg_d    = '0;
          rb_d    = '0;
          step_d  = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        {rr_d, dr_d} = div_step(rr_q, dr_q, cnt_q);
        {rg_d, dg_d} = div_step(rg_q, dg_q, cnt_q);
        {rb_d, db_d} = div_step(rb_q, db_q, cnt_q);
        step_d = step_q + 1'b1;
        if (step_q == DIV_LAST_STEP) begin
          rd_idx_d = '0;
          state_d  = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // A read goes out only when the output register is sure to be empty next cycle.
        if (!rd_vld_q && (rd_idx_q != cnt_q) && (!ov_q || out_ready_i)) begin
          rd_en_o  = 1'b1;
          rd_vld_d = 1'b1;
          ld_idx_d = rd_idx_q;
          rd_idx_d = rd_idx_q + 1'b1;
        end
        if (rd_vld_q) begin
          ov_d    = 1'b1;
          opix_d  = blended;
          orun_d  = ld_last;
          oline_d = ld_last && lend_q;
          if (ld_last) begin
            done_o  = 1'b1;
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign rd_addr_o       = {bank_q, rd_idx_q[IW-1:0]};
  assign out_valid_o     = ov_q;
  assign out_pixel_o     = opix_q;
  assign out_run_last_o  = orun_q;
  assign out_line_last_o = oline_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      rd_vld_q <= 1'b0;
      ov_q     <= 1'b0;
      step_q   <= '0;
      rd_idx_q <= '0;
      ld_idx_q <= '0;
      cnt_q    <= '0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= rd_vld_d;
      ov_q     <= ov_d;
      step_q   <= step_d;
      rd_idx_q <= rd_idx_d;
      ld_idx_q <= ld_idx_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bank_q  <= bank_d;
    lend_q  <= lend_d;
    dr_q    <= dr_d;
    dg_q    <= dg_d;
    db_q    <= db_d;
    rr_q    <= rr_d;
    rg_q    <= rg_d;
    rb_q    <= rb_d;
    opix_q  <= opix_d;
    orun_q  <= orun_d;
    oline_q <= oline_d;
  end

  a_load_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> !ov_q)
    else $error("read data arrives while output register is occupied");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !out_ready_i) |=> (ov_q && $stable(opix_q)))
    else $error("stalled result changed");

endmodule

`default_nettype wire

// ----- design/scanline_block_pixelate_core.sv -----
// Top level of the scanline block pixelation core: config registers and glue.
//
// Usage:
//   Pixels (RGB565) enter on the s_axis channel, tlast marking the last pixel
//   of a scanline. Pixels are grouped into horizontal blocks of block_size
//   (clamped to 2..16); a block also closes on tlast or when the effect is off.
//   Each closed block is emitted on m_axis in order, every pixel replaced by
//   or blended toward the block mean; tuser flags the last pixel of a block,
//   tlast the last pixel of a scanline.
//   Input: one pixel per cycle while a block buffer is free. Two banks of
//   block storage let the next block fill while the previous one drains.
//   Output: a closed block first runs through the bit-serial mean divider,
//   then each pixel passes a registered RAM read, then the output register;
//   a pixel is read only once the previous one has reached the output register.
//   Reset: enable 1, block_size 3, blend_weight 230; no partial block, empty
//   queue. The block memory needs no clearing.
//   Receiver stall: the output register holds its pixel; the back end pauses,
//   and the front end keeps taking pixels until both banks are occupied.
//   Config writes are always ready and should only be issued while idle.
`timescale 1ns / 1ps
`default_nettype none

module scanline_block_pixelate_core
  import sbp_pkg::*;
#(
  parameter int unsigned MAX_BLOCK = 16
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  // configuration write channel
  input  wire               cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire  [CFG_AW-1:0] cfg_addr_i,
  input  wire  [CFG_DW-1:0] cfg_data_i,
  // pixel input
  input  wire               s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  wire  [PIX_W-1:0]  s_axis_tdata_i,   // [15:0] pixel_in
  input  wire               s_axis_tlast_i,   // line_end
  // pixel output
  output logic              m_axis_tvalid_o,
  input  wire               m_axis_tready_i,
  output logic [PIX_W-1:0]  m_axis_tdata_o,   // [15:0] pixel_out
  output logic              m_axis_tuser_o,   // [0] run_last
  output logic              m_axis_tlast_o    // line_last
);

  localparam int unsigned BLK       = (MAX_BLOCK < MAX_SIZE) ? MAX_BLOCK : MAX_SIZE;
  localparam int unsigned IW        = $clog2(BLK);
  localparam int unsigned RAM_DEPTH = 1 << (IW + 1);

  logic             enable_q;
  logic [BSZ_W-1:0] bsize_q;
  logic [WGT_W-1:0] weight_q;
  logic [1:0]       pend_q, pend_d;   // closed blocks not yet fully read out

  logic             wr_en, rd_en;
  logic [IW:0]      wr_addr, rd_addr;
  logic [PIX_W-1:0] wr_data, rd_data;
  logic             push, pop, done;
  logic             q_empty, q_full;
  desc_t            push_desc, pop_desc;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b1;
      bsize_q  <= 5'd3;
      weight_q <= 9'd230;
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        CFG_ENABLE: enable_q <= cfg_data_i[0];
        CFG_BSIZE:  bsize_q  <= cfg_data_i[BSZ_W-1:0];
        CFG_WEIGHT: weight_q <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  always_comb begin
    pend_d = pend_q;
    if (push && !done) begin
      pend_d = pend_q + 1'b1;
    end else if (done && !push) begin
      pend_d = pend_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  sbp_front #(
    .BLK (BLK),
    .IW  (IW)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .pixel_i      (s_axis_tdata_i),
    .line_end_i   (s_axis_tlast_i),
    .bank_free_i  (pend_q < 2'd2),
    .enable_i     (enable_q),
    .block_size_i (bsize_q),
    .wr_en_o      (wr_en),
    .wr_addr_o    (wr_addr),
    .wr_data_o    (wr_data),
    .push_o       (push),
    .desc_o       (push_desc)
  );

  sbp_fifo #(
    .WIDTH ($bits(desc_t)),
    .DEPTH (2)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_desc),
    .pop_i   (pop),
    .rdata_o (pop_desc),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  sbp_ram #(
    .WIDTH (PIX_W),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  sbp_back #(
    .IW (IW)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .desc_valid_i    (!q_empty),
    .desc_i          (pop_desc),
    .pop_o           (pop),
    .enable_i        (enable_q),
    .weight_i        (weight_q),
    .rd_en_o         (rd_en),
    .rd_addr_o       (rd_addr),
    .rd_data_i       (rd_data),
    .out_valid_o     (m_axis_tvalid_o),
    .out_ready_i     (m_axis_tready_i),
    .out_pixel_o     (m_axis_tdata_o),
    .out_run_last_o  (m_axis_tuser_o),
    .out_line_last_o (m_axis_tlast_o),
    .done_o          (done)
  );

  a_pend_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q != 2'd3) && !(q_full && pend_q < 2'd2))
    else $error("pending block count out of step with queue");

endmodule

`default_nettype wire
